### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks for the docking sequencer, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

### rtl/mds_pkg.sv
// ----------------------------------------------------------------------------
// Docking sequencer package
// Codes, word layouts and fixed constants shared by the sequencer files.
// ----------------------------------------------------------------------------
package mds_pkg;

    localparam logic signed [12:0] FRAME_CENTRE  = 13'sd320;
    localparam logic signed [12:0] DOCK_MARGIN   = 13'sd20;
    localparam logic [10:0]        WIDTH_ERR_TOL = 11'd10;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_DETECT = 1'b1;

    typedef enum logic [2:0] {
        MODE_SEARCH,
        MODE_FOUND,
        MODE_APPROACH,
        MODE_ALIGN,
        MODE_DOCK,
        MODE_DOCKED
    } mode_t;

    typedef enum logic [2:0] {
        MV_NONE,
        MV_STOP,
        MV_TURN_L,
        MV_TURN_R,
        MV_SLIDE_L,
        MV_SLIDE_R,
        MV_FWD,
        MV_BACK
    } motion_t;

    typedef enum logic [2:0] {
        SP_NONE,
        SP_SEARCH,
        SP_APPROACH,
        SP_ALIGN,
        SP_DOCK
    } speed_t;

    typedef enum logic [2:0] {
        REG_STALE_TIMEOUT,
        REG_CENTRE_TOL,
        REG_WIDTH_MIN,
        REG_WIDTH_MAX,
        REG_DOCK_WIDTH,
        REG_DOCKED_WIDTH,
        REG_GAIN_SIDEWAYS,
        REG_GAIN_DISTANCE
    } cfg_index_t;

    typedef struct packed {
        logic               opcode;
        logic [31:0]        now_ms;
        logic signed [11:0] marker_x;
        logic [10:0]        marker_width;
        logic               id_nonempty;
        logic               id_is_front;
    } item_word_t;

    typedef struct packed {
        motion_t motion;
        speed_t  speed_class;
        mode_t   nav_mode;
        logic    detection_taken;
    } result_word_t;

endpackage

### rtl/mds_item_if.sv
// ----------------------------------------------------------------------------
// Item channel
// Valid/ready channel carrying one tick or detection word.
// ----------------------------------------------------------------------------
interface mds_item_if
    import mds_pkg::*;
;
    logic       valid;
    logic       ready;
    item_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/mds_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one motion command word.
// ----------------------------------------------------------------------------
interface mds_result_if
    import mds_pkg::*;
;
    logic         valid;
    logic         ready;
    result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/marker_docking_sequencer_top.sv
// ----------------------------------------------------------------------------
// Marker docking sequencer
// Stores marker detections and steps the docking state machine on ticks.
// ----------------------------------------------------------------------------
// Every word in gives exactly one result word. A word is registered at the
// input, then evaluated combinationally against the stored marker and the mode
// (a 12x12 and an 11x12 gain multiplier in parallel are the deepest path) and
// written to the result register, so a new word is taken every cycle as long
// as results are taken, and the result word is valid once the result register
// is written, which waits while a held result is not taken. Configuration is
// to be written through cfg_we/cfg_index/cfg_data only while no word is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module marker_docking_sequencer_top
    import mds_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    mds_item_if.sink     items,
    mds_result_if.source results
);

    logic [15:0] stale_timeout_reg;
    logic [9:0]  centre_tol_reg;
    logic [10:0] width_min_reg;
    logic [10:0] width_max_reg;
    logic [10:0] dock_width_reg;
    logic [10:0] docked_width_reg;
    logic [11:0] gain_side_reg;
    logic [11:0] gain_dist_reg;

    logic               in_valid_reg;
    item_word_t         in_reg;
    logic               out_valid_reg;
    result_word_t       out_reg;

    mode_t              mode_reg, mode_next;
    logic               marker_valid_reg, marker_valid_next;
    logic signed [11:0] stored_x_reg;
    logic [10:0]        stored_width_reg;
    logic               stored_front_reg;
    logic [31:0]        last_seen_reg;

    logic               fire;
    logic               is_detect;
    logic               det_ok;
    logic [31:0]        age;
    logic               stale;
    logic               valid_now;
    logic               lost;
    logic signed [12:0] xoff;
    logic [12:0]        xoff_abs;
    logic [11:0]        xoff_mag;
    logic               xoff_pos;
    logic signed [11:0] werr;
    logic [11:0]        werr_abs;
    logic [10:0]        werr_mag;
    logic               werr_pos;
    logic [23:0]        prod_x;
    logic [22:0]        prod_w;
    logic               tr_ge1, tr_ge2, fw_ge1;
    logic               near_dock;
    logic               centred;
    logic               off_centre;
    logic               width_ok;
    logic               docked_now;
    motion_t            motion;
    speed_t             speed;

    // hold config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_timeout_reg <= 16'd1000;
            centre_tol_reg    <= 10'd30;
            width_min_reg     <= 11'd20;
            width_max_reg     <= 11'd600;
            dock_width_reg    <= 11'd200;
            docked_width_reg  <= 11'd250;
            gain_side_reg     <= 12'd26;
            gain_dist_reg     <= 12'd26;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_STALE_TIMEOUT: stale_timeout_reg <= cfg_data;
                REG_CENTRE_TOL:    centre_tol_reg    <= cfg_data[9:0];
                REG_WIDTH_MIN:     width_min_reg     <= cfg_data[10:0];
                REG_WIDTH_MAX:     width_max_reg     <= cfg_data[10:0];
                REG_DOCK_WIDTH:    dock_width_reg    <= cfg_data[10:0];
                REG_DOCKED_WIDTH:  docked_width_reg  <= cfg_data[10:0];
                REG_GAIN_SIDEWAYS: gain_side_reg     <= cfg_data[11:0];
                REG_GAIN_DISTANCE: gain_dist_reg     <= cfg_data[11:0];
                default:           stale_timeout_reg <= stale_timeout_reg;
            endcase
        end
    end

    assign fire          = in_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready   = !in_valid_reg || fire;
    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            in_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            in_reg <= items.data;
        end
    end

    assign is_detect = (in_reg.opcode == OP_DETECT);
    assign det_ok    = in_reg.id_nonempty
                       && (in_reg.marker_width >= width_min_reg)
                       && (in_reg.marker_width <= width_max_reg);

    assign age       = in_reg.now_ms - last_seen_reg;
    assign stale     = marker_valid_reg && (age > {16'd0, stale_timeout_reg});
    assign valid_now = marker_valid_reg && !stale;
    assign lost      = stale && (mode_reg != MODE_SEARCH) && (mode_reg != MODE_DOCKED);

    assign xoff     = {stored_x_reg[11], stored_x_reg} - FRAME_CENTRE;
    assign xoff_abs = xoff[12] ? 13'(-xoff) : 13'(xoff);
    assign xoff_mag = xoff_abs[11:0];
    assign xoff_pos = !xoff[12] && (xoff_mag != 12'd0);

    assign werr     = $signed({1'b0, stored_width_reg}) - $signed({1'b0, dock_width_reg});
    assign werr_abs = werr[11] ? 12'(-werr) : 12'(werr);
    assign werr_mag = werr_abs[10:0];
    assign werr_pos = !werr[11] && (werr_mag != 11'd0);

    assign prod_x = xoff_mag * gain_side_reg;
    assign prod_w = werr_mag * gain_dist_reg;
    assign tr_ge1 = |prod_x[23:8];
    assign tr_ge2 = |prod_x[23:9];
    assign fw_ge1 = |prod_w[22:8];

    assign near_dock  = $signed({2'b00, stored_width_reg})
                        >= ($signed({2'b00, dock_width_reg}) - DOCK_MARGIN);
    assign centred    = (xoff_mag < {2'b00, centre_tol_reg});
    assign off_centre = (xoff_mag > {2'b00, centre_tol_reg});
    assign width_ok   = (werr_mag < WIDTH_ERR_TOL);
    assign docked_now = (stored_width_reg >= docked_width_reg);

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (!is_detect)
        begin
            if (lost)
            begin
                mode_next = MODE_SEARCH;
            end
            else
            begin
                case (mode_reg)
                    MODE_DOCKED:   mode_next = MODE_DOCKED;
                    MODE_FOUND:    mode_next = (valid_now && stored_front_reg)
                                               ? MODE_APPROACH : MODE_SEARCH;
                    MODE_APPROACH:
                    begin
                        if (!valid_now)
                            mode_next = MODE_SEARCH;
                        else if (near_dock)
                            mode_next = MODE_ALIGN;
                    end
                    MODE_ALIGN:
                    begin
                        if (!valid_now)
                            mode_next = MODE_SEARCH;
                        else if (centred && width_ok)
                            mode_next = MODE_DOCK;
                    end
                    MODE_DOCK:
                    begin
                        if (!valid_now)
                            mode_next = MODE_SEARCH;
                        else if (docked_now)
                            mode_next = MODE_DOCKED;
                    end
                    default:       mode_next = valid_now ? MODE_FOUND : MODE_SEARCH;
                endcase
            end
        end
    end

    // motion and speed
    always_comb
    begin
        motion = MV_NONE;
        speed  = SP_NONE;
        if (!is_detect)
        begin
            if (lost)
            begin
                motion = MV_STOP;
            end
            else
            begin
                case (mode_reg)
                    MODE_DOCKED: motion = MV_STOP;
                    MODE_FOUND:  motion = MV_NONE;
                    MODE_APPROACH:
                    begin
                        if (valid_now && !near_dock)
                        begin
                            speed = SP_APPROACH;
                            if (tr_ge2 && xoff_pos)
                                motion = MV_SLIDE_R;
                            else if (tr_ge2)
                                motion = MV_SLIDE_L;
                            else
                                motion = MV_FWD;
                        end
                    end
                    MODE_ALIGN:
                    begin
                        if (valid_now && !(centred && width_ok))
                        begin
                            speed = SP_ALIGN;
                            if (tr_ge1 && xoff_pos)
                                motion = MV_SLIDE_R;
                            else if (tr_ge1)
                                motion = MV_SLIDE_L;
                            else if (fw_ge1 && werr_pos)
                                motion = MV_FWD;
                            else if (fw_ge1)
                                motion = MV_BACK;
                            else
                            begin
                                motion = MV_STOP;
                                speed  = SP_NONE;
                            end
                        end
                    end
                    MODE_DOCK:
                    begin
                        if (valid_now)
                        begin
                            if (docked_now)
                                motion = MV_STOP;
                            else if (off_centre)
                            begin
                                motion = xoff_pos ? MV_SLIDE_R : MV_SLIDE_L;
                                speed  = SP_ALIGN;
                            end
                            else
                            begin
                                motion = MV_FWD;
                                speed  = SP_DOCK;
                            end
                        end
                    end
                    default:
                    begin
                        if (valid_now)
                            motion = MV_STOP;
                        else
                        begin
                            motion = MV_TURN_L;
                            speed  = SP_SEARCH;
                        end
                    end
                endcase
            end
        end
    end

    assign marker_valid_next = is_detect ? (marker_valid_reg || det_ok) : valid_now;

    // advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_SEARCH;
            marker_valid_reg <= 1'b0;
            stored_x_reg     <= '0;
            stored_width_reg <= '0;
            stored_front_reg <= 1'b0;
            last_seen_reg    <= '0;
        end
        else if (fire)
        begin
            mode_reg         <= mode_next;
            marker_valid_reg <= marker_valid_next;
            if (is_detect && det_ok)
            begin
                stored_x_reg     <= in_reg.marker_x;
                stored_width_reg <= in_reg.marker_width;
                stored_front_reg <= in_reg.id_is_front;
                last_seen_reg    <= in_reg.now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg.motion          <= motion;
            out_reg.speed_class     <= speed;
            out_reg.nav_mode        <= mode_next;
            out_reg.detection_taken <= is_detect && det_ok;
        end
    end

    `ASSERT_IMPLIES(a_idle_speed, clk, rst_n,
        results.valid && (results.data.motion == MV_STOP || results.data.motion == MV_NONE),
        results.data.speed_class == SP_NONE)
    `ASSERT_NEXT(a_taken_marks_valid, clk, rst_n, fire && is_detect && det_ok,
        marker_valid_reg && results.data.detection_taken)
    `ASSERT_NEXT(a_detect_holds_mode, clk, rst_n, fire && is_detect,
        mode_reg == $past(mode_reg) && results.data.motion == MV_NONE)

endmodule
